// ----- rtl/wca_pkg.sv -----
// Package for the WCA pair force unit: widths, register indexes, back-end states.
// No dependencies.
package wca_pkg;
   localparam int DEL_W = 32;
   localparam int COEF_W = 32;
   localparam int FRC_W = 48;
   localparam int ENG_W = 64;
   localparam int CSR_IDX_W = 3;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CUTOFF_SQ = 3'd0,
      REG_REP_FORCE = 3'd1,
      REG_ATT_FORCE = 3'd2,
      REG_REP_ENERGY = 3'd3,
      REG_ATT_ENERGY = 3'd4,
      REG_ENERGY_SHIFT = 3'd5
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_MUL, ST_FMT, ST_OUT
   } back_state_type;

   // classified pair handed from front to back
   typedef struct packed {
      logic [DEL_W-1:0] mag_x;
      logic [DEL_W-1:0] mag_y;
      logic [DEL_W-1:0] mag_z;
      logic neg_x;
      logic neg_y;
      logic neg_z;
      logic [63:0] rsq;
      logic hit;
      logic last_pair;
   } pair_type;

   typedef struct packed {
      logic [COEF_W-1:0] cutoff_sq;
      logic [COEF_W-1:0] rep_force_coef;
      logic [COEF_W-1:0] att_force_coef;
      logic [COEF_W-1:0] rep_energy_coef;
      logic [COEF_W-1:0] att_energy_coef;
      logic [COEF_W-1:0] energy_shift;
   } coef_type;
endpackage

// ----- rtl/wca_if.sv -----
// Channel interfaces for the WCA pair force unit.
// Depends on wca_pkg.
interface wca_req_if import wca_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [DEL_W-1:0] del_x;
   logic signed [DEL_W-1:0] del_y;
   logic signed [DEL_W-1:0] del_z;
   logic last_pair;
   modport source (output valid, del_x, del_y, del_z, last_pair, input ready);
   modport sink (input valid, del_x, del_y, del_z, last_pair, output ready);
endinterface

interface wca_rsp_if import wca_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [FRC_W-1:0] force_x;
   logic signed [FRC_W-1:0] force_y;
   logic signed [FRC_W-1:0] force_z;
   logic in_range;
   logic signed [ENG_W-1:0] energy_total;
   logic run_end;
   modport source (output valid, force_x, force_y, force_z, in_range, energy_total,
      run_end, input ready);
   modport sink (input valid, force_x, force_y, force_z, in_range, energy_total,
      run_end, output ready);
endinterface

interface wca_csr_if import wca_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COEF_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/wca_front.sv -----
// Front end: takes pairs, forms magnitudes and squared distance, classifies range.
// Depends on wca_pkg; rsq is registered into a two-entry queue.
module wca_front import wca_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [DEL_W-1:0] del_x,
   input  logic [DEL_W-1:0] del_y,
   input  logic [DEL_W-1:0] del_z,
   input  logic last_pair,
   input  logic [COEF_W-1:0] cutoff_sq,
   output logic q_valid,
   input  logic q_ready,
   output pair_type q_pair
);
   localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
   pair_type mem_ff [Depth];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0] cnt_ff, cnt_in;
   pair_type p;
   logic [31:0] mx, my, mz;
   logic [63:0] sx, sy, sz;
   logic push, pop;

   function automatic logic [31:0] mag(input logic [31:0] v);
      mag = v[31] ? (~v + 32'd1) : v;
   endfunction

   always_comb begin
      mx = mag(del_x);
      my = mag(del_y);
      mz = mag(del_z);
      sx = {32'd0, mx} * {32'd0, mx};
      sy = {32'd0, my} * {32'd0, my};
      sz = {32'd0, mz} * {32'd0, mz};
      p.mag_x = mx;
      p.mag_y = my;
      p.mag_z = mz;
      p.neg_x = del_x[31];
      p.neg_y = del_y[31];
      p.neg_z = del_z[31];
      p.rsq = sx + sy + sz;
      p.hit = p.rsq < {cutoff_sq, 32'd0};
      p.last_pair = last_pair;
   end

   assign req_ready = cnt_ff < (PW+1)'(Depth);
   assign push = req_valid && req_ready;
   assign pop = q_valid && q_ready;
   assign q_valid = cnt_ff != '0;
   assign q_pair = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (push) wp_in = (wp_ff == PW'(Depth-1)) ? '0 : wp_ff + PW'(1);
      if (pop) rp_in = (rp_ff == PW'(Depth-1)) ? '0 : rp_ff + PW'(1);
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= p;
   end

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(Depth)) else $error("queue overflow");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == (PW+1)'(Depth)) |-> !push) else $error("push into full queue");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> !pop) else $error("pop from empty queue");
`endif
endmodule

// ----- rtl/wca_back.sv -----
// Back end: radix-2 reciprocal, shared 64x64 multiplier stepped over cycles, output.
// Depends on wca_pkg.
module wca_back import wca_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_ready,
   input  pair_type q_pair,
   input  coef_type coef,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [FRC_W-1:0] force_x,
   output logic [FRC_W-1:0] force_y,
   output logic [FRC_W-1:0] force_z,
   output logic in_range,
   output logic [ENG_W-1:0] energy_total,
   output logic run_end
);
   localparam logic [63:0] SAT = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [47:0] POS48 = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] NEG48 = 48'h8000_0000_0000;

   back_state_type st_ff, st_in;
   pair_type pr_ff;
   logic [6:0] step_ff, step_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] r2_ff, r2_in, r6_ff, r6_in, t_ff, t_in, fp_ff, fp_in, em_ff, em_in;
   logic fneg_ff, fneg_in, eneg_ff, eneg_in;
   logic [3:0] op_ff, op_in;
   logic [63:0] ma, mb;
   logic [5:0] msh;
   logic [63:0] mres;
   logic [63:0] pp_ff [4];
   logic [63:0] sum_ff, sum_in;
   logic [FRC_W-1:0] fx_ff, fy_ff, fz_ff, fx_in, fy_in, fz_in;
   logic hit_ff, hit_in, end_ff, end_in, ov_ff;
   logic [ENG_W-1:0] et_ff, et_in;
   logic [64:0] rsh;
   logic [63:0] cmp;
   logic signed [64:0] e65, s65;
   logic signed [63:0] e64;
   logic [1:0] ph_ff, ph_in;
   logic [127:0] full;
   logic [95:0] mid;

   // partial products registered, combined next cycle (ph 0: launch, 1: combine, 2: capture)
   always_ff @(posedge clock) begin
      pp_ff[0] <= {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
      pp_ff[1] <= {32'd0, ma[31:0]} * {32'd0, mb[63:32]};
      pp_ff[2] <= {32'd0, ma[63:32]} * {32'd0, mb[31:0]};
      pp_ff[3] <= {32'd0, ma[63:32]} * {32'd0, mb[63:32]};
   end

   always_comb begin
      mid = {32'd0, pp_ff[1]} + {32'd0, pp_ff[2]} + {64'd0, pp_ff[0][63:32]};
      full = {pp_ff[3], 64'd0} + {mid, 32'd0} + {96'd0, pp_ff[0][31:0]};
      if (msh == 6'd16) mres = (full[127:80] != '0) ? SAT : full[79:16];
      else mres = (full[127:96] != '0) ? SAT : full[95:32];
   end

   function automatic logic [47:0] fout(input logic [63:0] m, input logic neg);
      logic [47:0] r;
      if (neg) r = (m > {16'd0, NEG48}) ? NEG48 : (~m[47:0] + 48'd1);
      else r = (m > {16'd0, POS48}) ? POS48 : m[47:0];
      return r;
   endfunction

   // op sequence: 0 r2*r2,1 *r2=r6,2 lj1*r6,3 r6*fdiff,4 *r2=fpair,5 lj3*r6,6 r6*ediff,
   // 7 dx,8 dy,9 dz
   always_comb begin
      ma = r2_ff; mb = r2_ff; msh = 6'd32;
      unique case (op_ff)
         4'd0: begin ma = r2_ff; mb = r2_ff; end
         4'd1: begin ma = t_ff; mb = r2_ff; end
         4'd2: begin ma = {32'd0, coef.rep_force_coef}; mb = r6_ff; msh = 6'd16; end
         4'd3: begin ma = r6_ff; mb = t_ff; end
         4'd4: begin ma = t_ff; mb = r2_ff; end
         4'd5: begin ma = {32'd0, coef.rep_energy_coef}; mb = r6_ff; msh = 6'd16; end
         4'd6: begin ma = r6_ff; mb = t_ff; end
         4'd7: begin ma = {32'd0, pr_ff.mag_x}; mb = fp_ff; end
         4'd8: begin ma = {32'd0, pr_ff.mag_y}; mb = fp_ff; end
         4'd9: begin ma = {32'd0, pr_ff.mag_z}; mb = fp_ff; end
         default: begin ma = r2_ff; mb = r2_ff; end
      endcase
   end

   always_comb begin
      st_in = st_ff; step_in = step_ff; rem_in = rem_ff; q_in = q_ff;
      r2_in = r2_ff; r6_in = r6_ff; t_in = t_ff; fp_in = fp_ff; em_in = em_ff;
      fneg_in = fneg_ff; eneg_in = eneg_ff; op_in = op_ff; ph_in = ph_ff;
      sum_in = sum_ff; fx_in = fx_ff; fy_in = fy_ff; fz_in = fz_ff;
      hit_in = hit_ff; end_in = end_ff; et_in = et_ff;
      q_ready = 1'b0;
      rsh = '0; cmp = '0; e65 = '0; s65 = '0; e64 = '0;
      unique case (st_ff)
         ST_IDLE: begin
            q_ready = !rsp_valid || rsp_ready;
            if (q_valid && q_ready) begin
               hit_in = q_pair.hit;
               end_in = q_pair.last_pair;
               fx_in = '0; fy_in = '0; fz_in = '0;
               rem_in = '0; q_in = '0; step_in = 7'd80;
               op_in = 4'd0; ph_in = 2'd0;
               if (!q_pair.hit) st_in = ST_FMT;
               else if (q_pair.rsq <= 64'h1_0000) begin
                  r2_in = SAT; st_in = ST_MUL;
               end else st_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rsh = {rem_ff[63:0], (step_ff == 7'd80)};
            if (rem_ff[63] || rsh >= {1'b0, pr_ff.rsq}) begin
               rem_in = rsh - {1'b0, pr_ff.rsq};
               q_in = {q_ff[62:0], 1'b1};
            end else begin
               rem_in = rsh;
               q_in = {q_ff[62:0], 1'b0};
            end
            if (step_ff == '0) begin
               r2_in = q_in; st_in = ST_MUL;
            end else step_in = step_ff - 7'd1;
         end
         ST_MUL: begin
            if (ph_ff == 2'd0) ph_in = 2'd1;
            else if (ph_ff == 2'd1) ph_in = 2'd2;
            else begin
               ph_in = 2'd0;
               op_in = op_ff + 4'd1;
               unique case (op_ff)
                  4'd0: t_in = mres;
                  4'd1: r6_in = mres;
                  4'd2: begin
                     cmp = {16'd0, coef.att_force_coef, 16'd0};
                     fneg_in = mres < cmp;
                     t_in = (mres >= cmp) ? mres - cmp : cmp - mres;
                  end
                  4'd3: t_in = mres;
                  4'd4: fp_in = mres;
                  4'd5: begin
                     cmp = {16'd0, coef.att_energy_coef, 16'd0};
                     eneg_in = mres < cmp;
                     t_in = (mres >= cmp) ? mres - cmp : cmp - mres;
                  end
                  4'd6: em_in = mres;
                  4'd7: fx_in = fout(mres, pr_ff.neg_x ^ fneg_ff);
                  4'd8: fy_in = fout(mres, pr_ff.neg_y ^ fneg_ff);
                  4'd9: begin
                     fz_in = fout(mres, pr_ff.neg_z ^ fneg_ff);
                     st_in = ST_FMT;
                  end
                  default: st_in = ST_FMT;
               endcase
            end
         end
         ST_FMT: begin
            if (hit_ff) begin
               if (eneg_ff) e64 = em_ff[63] ? 64'sh8000_0000_0000_0000 : -$signed(em_ff);
               else e64 = em_ff[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(em_ff);
               e65 = {e64[63], e64} + $signed({17'd0, coef.energy_shift, 16'd0});
               if (e65[64] != e65[63]) e64 = e65[64] ? 64'sh8000_0000_0000_0000
                  : 64'sh7FFF_FFFF_FFFF_FFFF;
               else e64 = e65[63:0];
               s65 = {sum_ff[63], sum_ff} + {e64[63], e64};
               if (s65[64] != s65[63]) sum_in = s65[64] ? 64'h8000_0000_0000_0000
                  : 64'h7FFF_FFFF_FFFF_FFFF;
               else sum_in = s65[63:0];
            end
            et_in = sum_in;
            if (end_ff) sum_in = '0;
            st_in = ST_OUT;
         end
         ST_OUT: begin
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         sum_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         sum_ff <= sum_in;
         if (st_ff == ST_OUT) ov_ff <= 1'b1;
         else if (rsp_ready) ov_ff <= 1'b0;
      end
      if (st_ff == ST_IDLE && q_valid && q_ready) pr_ff <= q_pair;
      step_ff <= step_in; rem_ff <= rem_in; q_ff <= q_in;
      r2_ff <= r2_in; r6_ff <= r6_in; t_ff <= t_in; fp_ff <= fp_in; em_ff <= em_in;
      fneg_ff <= fneg_in; eneg_ff <= eneg_in; op_ff <= op_in; ph_ff <= ph_in;
      fx_ff <= fx_in; fy_ff <= fy_in; fz_ff <= fz_in;
      hit_ff <= hit_in; end_ff <= end_in; et_ff <= et_in;
   end

   assign rsp_valid = ov_ff;
   assign force_x = fx_ff;
   assign force_y = fy_ff;
   assign force_z = fz_ff;
   assign in_range = hit_ff;
   assign energy_total = et_ff;
   assign run_end = end_ff;

`ifndef SYNTH
   a_busy_noready: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !q_ready) else $error("queue popped while busy");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_OUT) |=> rsp_valid) else $error("result not presented");
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_FMT && end_ff) |=> (sum_ff == '0)) else $error("sum not cleared");
`endif
endmodule

// ----- rtl/wca_pair_force_unit.sv -----
// Top level of the WCA pair force unit: config registers, front end, back end.
// Depends on wca_pkg, wca_if, wca_front, wca_back.
// One neighbor pair per transaction. The front end classifies a pair combinationally
// and queues it (two entries). The back end runs one pair at a time: a radix-2
// reciprocal for in-range pairs (skipped, with r2 saturated, when rsq is at most
// 0x10000), then ten products on one shared 64x64 multiplier, then ST_FMT
// accumulates the energy and ST_OUT presents the result; out-of-range pairs go
// straight to ST_FMT. Coefficient writes are taken at any time with ready held high.
module wca_pair_force_unit import wca_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input logic clock,
   input logic reset,
   wca_req_if.sink req,
   wca_rsp_if.source rsp,
   wca_csr_if.sink csr
);
   coef_type coef_ff, coef_in;
   logic qv, qr;
   pair_type qp;

   assign csr.ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (csr.valid) begin
         unique case (csr.index)
            REG_CUTOFF_SQ: coef_in.cutoff_sq = csr.data;
            REG_REP_FORCE: coef_in.rep_force_coef = csr.data;
            REG_ATT_FORCE: coef_in.att_force_coef = csr.data;
            REG_REP_ENERGY: coef_in.rep_energy_coef = csr.data;
            REG_ATT_ENERGY: coef_in.att_energy_coef = csr.data;
            REG_ENERGY_SHIFT: coef_in.energy_shift = csr.data;
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.cutoff_sq <= 32'd82570;
         coef_ff.rep_force_coef <= 32'd3145728;
         coef_ff.att_force_coef <= 32'd1572864;
         coef_ff.rep_energy_coef <= 32'd262144;
         coef_ff.att_energy_coef <= 32'd262144;
         coef_ff.energy_shift <= 32'd65536;
      end else begin
         coef_ff <= coef_in;
      end
   end

   wca_front #(.Depth(QueueDepth)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .del_x(req.del_x), .del_y(req.del_y), .del_z(req.del_z),
      .last_pair(req.last_pair), .cutoff_sq(coef_ff.cutoff_sq),
      .q_valid(qv), .q_ready(qr), .q_pair(qp)
   );

   wca_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(qv), .q_ready(qr), .q_pair(qp), .coef(coef_ff),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .force_x(rsp.force_x), .force_y(rsp.force_y), .force_z(rsp.force_z),
      .in_range(rsp.in_range), .energy_total(rsp.energy_total), .run_end(rsp.run_end)
   );
endmodule
